// ===== design/tws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg
// shared types and constants of the timing wheel scheduler
// ----------------------------------------------------------------------------
package tws_pkg;
  localparam int WHEEL_SLOTS_DEF = 64;
  localparam int MAX_TASKS_DEF   = 64;
  localparam int TIME_W          = 48;
  localparam int ID_W            = 6;

  localparam logic [1:0] ST_ADDED    = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_EXPIRED  = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  typedef struct packed {
    logic load;       // capture request, apply first-item rule
    logic add_check;  // register add checks and slot address
    logic add_write;  // update memories for an accepted add
    logic ex_init;    // set up slot walk
    logic ex_slot;    // read slot entry at walk index
    logic ex_task;    // emit current task, step list
    logic ex_done;    // finish expire
  } tws_cmd_t;

  typedef struct packed {
    logic is_expire;
    logic add_ok;
    logic slot_busy;   // current walked slot is nonempty
    logic walk_end;    // every due slot walked, or now is before the start time
    logic list_end;    // current task is the slot tail or guard hit
    logic any_out;     // an expired task was emitted
  } tws_stat_t;
endpackage

// ===== design/timing_wheel_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timing_wheel_scheduler
// single-level timing wheel of millisecond slots with per-slot task lists
// ----------------------------------------------------------------------------
// channel   signals                                  handshake
// request   action now task_id expire_time           start && !busy
// result    status task_id_res last                  done, one cycle
//
// an add result leaves tws_out after the load, check and write states
// an expire walks the wheel: each walked slot passes the slot and wait
// states, and each listed task passes the task state
// rst is synchronous and clears the wheel valid bits at once, no sweep
// results cannot be stalled; busy drops in the cycle of the last result
// ----------------------------------------------------------------------------
module timing_wheel_scheduler #(
  parameter int WHEEL_SLOTS = tws_pkg::WHEEL_SLOTS_DEF,
  parameter int MAX_TASKS   = tws_pkg::MAX_TASKS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     action,
  input  logic [tws_pkg::TIME_W-1:0] now,
  input  logic [tws_pkg::ID_W-1:0] task_id,
  input  logic [tws_pkg::TIME_W-1:0] expire_time,
  output logic                     done,
  output logic [1:0]               status,
  output logic [tws_pkg::ID_W-1:0] task_id_res,
  output logic                     last
);
  tws_pkg::tws_cmd_t  cmd;
  tws_pkg::tws_stat_t stat;
  logic                     d_vld;
  logic [1:0]               d_status;
  logic [tws_pkg::ID_W-1:0] d_id;
  logic                     d_last;
  logic                     flush;
  logic                     c_busy;

  tws_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd),
    .busy(c_busy), .flush(flush)
  );

  tws_datapath #(.WHEEL_SLOTS(WHEEL_SLOTS), .MAX_TASKS(MAX_TASKS)) u_dp (
    .clk(clk), .rst(rst), .action(action), .now(now), .task_id(task_id),
    .expire_time(expire_time), .cmd(cmd), .stat(stat), .done(d_vld),
    .status(d_status), .task_id_res(d_id), .last(d_last)
  );

  tws_out u_out (
    .clk(clk), .rst(rst), .in_vld(d_vld), .in_status(d_status), .in_id(d_id),
    .in_last(d_last), .flush(flush), .done(done), .status(status),
    .task_id_res(task_id_res), .last(last)
  );

  assign busy = c_busy || d_vld;
endmodule

// ===== design/tws_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_datapath
// wheel state, slot and task memories, result registers
// ----------------------------------------------------------------------------
module tws_datapath #(
  parameter int WHEEL_SLOTS = tws_pkg::WHEEL_SLOTS_DEF,
  parameter int MAX_TASKS   = tws_pkg::MAX_TASKS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     action,
  input  logic [tws_pkg::TIME_W-1:0] now,
  input  logic [tws_pkg::ID_W-1:0] task_id,
  input  logic [tws_pkg::TIME_W-1:0] expire_time,
  input  tws_pkg::tws_cmd_t        cmd,
  output tws_pkg::tws_stat_t       stat,
  output logic                     done,
  output logic [1:0]               status,
  output logic [tws_pkg::ID_W-1:0] task_id_res,
  output logic                     last
);
  localparam int SW = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = SW + 1;
  localparam int TWD = tws_pkg::TIME_W;

  logic           started;
  logic [TWD-1:0] start_time;
  logic [SW-1:0]  start_slot;
  logic [WHEEL_SLOTS-1:0] slot_nonempty;
  logic [MAX_TASKS-1:0]   task_pending;
  logic [TW-1:0] slot_head [WHEEL_SLOTS];
  logic [TW-1:0] slot_tail [WHEEL_SLOTS];
  logic [TW-1:0] next_task [MAX_TASKS];

  logic           r_action;
  logic [TWD-1:0] r_now;
  logic [tws_pkg::ID_W-1:0] r_id;
  logic [TWD-1:0] r_exp;
  logic           add_ok;
  logic [SW-1:0]  add_slot;
  logic           add_ne;
  logic [TW-1:0]  add_tail;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  walk_i;
  logic           cur_ne;
  logic [TW-1:0]  cur_t;
  logic [TW-1:0]  cur_tail;
  logic [TW:0]    guard;
  logic           any_out;
  logic [TW:0]    n_out;

  logic [TWD-1:0] st_eff;
  logic [TWD-1:0] diff;
  logic [TWD-1:0] span;
  logic [SW:0]    slot_sum;
  logic [SW-1:0]  chk_slot;
  logic [SW-1:0]  walk_slot;
  logic [SW:0]    walk_sum;
  logic [SW:0]    fin_sum;
  logic           id_ok;

  assign st_eff = start_time;
  assign diff = r_exp - st_eff;
  assign span = r_now - st_eff;
  assign slot_sum = {1'b0, start_slot} + diff[SW:0];
  assign chk_slot = (slot_sum >= (SW+1)'(WHEEL_SLOTS)) ?
                    SW'(slot_sum - (SW+1)'(WHEEL_SLOTS)) : slot_sum[SW-1:0];
  assign walk_sum = {1'b0, start_slot} + walk_i[SW:0];
  assign walk_slot = (walk_sum >= (SW+1)'(WHEEL_SLOTS)) ?
                     SW'(walk_sum - (SW+1)'(WHEEL_SLOTS)) : walk_sum[SW-1:0];
  assign fin_sum = {1'b0, start_slot} + cnt[SW:0] - (SW+1)'(1);
  assign id_ok = ({1'b0, r_id} < (tws_pkg::ID_W+1)'(MAX_TASKS));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_action <= action;
      r_now    <= now;
      r_id     <= task_id;
      r_exp    <= expire_time;
    end
    if (cmd.add_check) begin
      add_slot <= chk_slot;
      add_tail <= slot_tail[chk_slot];
      add_ne   <= slot_nonempty[chk_slot];
    end
    if (cmd.ex_init) begin
      cnt <= (span >= TWD'(WHEEL_SLOTS)) ? CW'(WHEEL_SLOTS) : CW'(span + TWD'(1));
    end
    if (cmd.ex_slot) begin
      cur_ne   <= slot_nonempty[walk_slot];
      cur_t    <= slot_head[walk_slot];
      cur_tail <= slot_tail[walk_slot];
    end else if (cmd.ex_task) begin
      cur_t <= next_task[cur_t];
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.add_write && add_ok) begin
      if (add_ne) begin
        next_task[add_tail] <= TW'(r_id);
      end else begin
        slot_head[add_slot] <= TW'(r_id);
      end
      slot_tail[add_slot] <= TW'(r_id);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      start_time    <= '0;
      start_slot    <= '0;
      slot_nonempty <= '0;
      task_pending  <= '0;
      add_ok        <= 1'b0;
      walk_i        <= '0;
      guard         <= '0;
      any_out       <= 1'b0;
      n_out         <= '0;
      done          <= 1'b0;
      status        <= '0;
      task_id_res   <= '0;
      last          <= 1'b0;
    end else begin
      done <= 1'b0;
      last <= 1'b0;
      if (cmd.load && !started) begin
        started    <= 1'b1;
        start_time <= now;
        start_slot <= '0;
      end
      if (cmd.add_check) begin
        add_ok <= !(r_now < start_time) && !(r_exp < r_now) && id_ok &&
                  !task_pending[TW'(r_id)] && (diff < TWD'(WHEEL_SLOTS));
      end
      if (cmd.add_write) begin
        if (add_ok) begin
          slot_nonempty[add_slot] <= 1'b1;
          task_pending[TW'(r_id)] <= 1'b1;
        end
        done        <= 1'b1;
        status      <= add_ok ? tws_pkg::ST_ADDED : tws_pkg::ST_REJECTED;
        task_id_res <= '0;
        last        <= 1'b1;
      end
      if (cmd.ex_init) begin
        walk_i  <= '0;
        any_out <= 1'b0;
        n_out   <= '0;
      end
      if (cmd.ex_slot) begin
        walk_i <= walk_i + CW'(1);
        guard  <= '0;
        if (slot_nonempty[walk_slot]) begin
          slot_nonempty[walk_slot] <= 1'b0;
        end
      end
      if (cmd.ex_task) begin
        guard <= guard + (TW+1)'(1);
        task_pending[cur_t] <= 1'b0;
        if (task_pending[cur_t] && n_out < (TW+1)'(MAX_TASKS)) begin
          done        <= 1'b1;
          status      <= tws_pkg::ST_EXPIRED;
          task_id_res <= tws_pkg::ID_W'(cur_t);
          any_out     <= 1'b1;
          n_out       <= n_out + (TW+1)'(1);
        end
      end
      if (cmd.ex_done) begin
        if (!(r_now < start_time)) begin
          start_time <= r_now;
          start_slot <= (fin_sum >= (SW+1)'(WHEEL_SLOTS)) ?
                        SW'(fin_sum - (SW+1)'(WHEEL_SLOTS)) : fin_sum[SW-1:0];
        end
        if (!any_out || r_now < start_time) begin
          done        <= 1'b1;
          status      <= tws_pkg::ST_NONE;
          task_id_res <= '0;
          last        <= 1'b1;
        end
      end
    end
  end

  // status flags fed back to the controller
  assign stat.is_expire = r_action;
  assign stat.add_ok    = add_ok;
  assign stat.slot_busy = cur_ne;
  assign stat.walk_end  = (walk_i >= cnt) || (r_now < start_time);
  assign stat.list_end  = (cur_t == cur_tail) || (guard >= (TW+1)'(MAX_TASKS - 1));
  assign stat.any_out   = any_out;
endmodule

// ===== design/tws_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_out
// one-deep result delay that marks the final result of a request
// ----------------------------------------------------------------------------
module tws_out (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_vld,
  input  logic [1:0]               in_status,
  input  logic [tws_pkg::ID_W-1:0] in_id,
  input  logic                     in_last,
  input  logic                     flush,
  output logic                     done,
  output logic [1:0]               status,
  output logic [tws_pkg::ID_W-1:0] task_id_res,
  output logic                     last
);
  logic                     h_vld;
  logic [1:0]               h_status;
  logic [tws_pkg::ID_W-1:0] h_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
      done  <= 1'b0;
      last  <= 1'b0;
    end else begin
      done <= 1'b0;
      last <= 1'b0;
      if (in_vld && in_last) begin
        if (h_vld) begin
          done <= 1'b1;
          last <= 1'b0;
          status <= h_status;
          task_id_res <= h_id;
          h_vld <= 1'b1;
          h_status <= in_status;
          h_id <= in_id;
        end else begin
          done <= 1'b1;
          last <= 1'b1;
          status <= in_status;
          task_id_res <= in_id;
        end
      end else if (in_vld) begin
        if (h_vld) begin
          done <= 1'b1;
          status <= h_status;
          task_id_res <= h_id;
        end
        h_vld <= 1'b1;
        h_status <= in_status;
        h_id <= in_id;
      end else if (flush && h_vld) begin
        done <= 1'b1;
        last <= 1'b1;
        status <= h_status;
        task_id_res <= h_id;
        h_vld <= 1'b0;
      end
    end
  end
endmodule

// ===== design/tws_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_ctrl
// controller sequencing adds and the expire walk
// ----------------------------------------------------------------------------
module tws_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tws_pkg::tws_stat_t stat,
  output tws_pkg::tws_cmd_t  cmd,
  output logic               busy,
  output logic               flush
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_WRITE = 9'b000001000,
    S_INIT  = 9'b000010000,
    S_SLOT  = 9'b000100000,
    S_WAIT  = 9'b001000000,
    S_TASK  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    flush = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.is_expire) begin
          cmd.ex_init = 1'b1;
          state_next = S_SLOT;
        end else begin
          cmd.add_check = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.add_write = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: state_next = S_IDLE;
      S_INIT: state_next = S_SLOT;
      S_SLOT: begin
        if (stat.walk_end) begin
          cmd.ex_done = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.ex_slot = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: state_next = stat.slot_busy ? S_TASK : S_SLOT;
      S_TASK: begin
        cmd.ex_task = 1'b1;
        state_next = stat.list_end ? S_SLOT : S_TASK;
      end
      S_DONE: begin
        flush = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule

// ===== design/tws_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_checker
// port-level checks of the timing wheel scheduler
// ----------------------------------------------------------------------------
module tws_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic [1:0]               status,
  input logic [tws_pkg::ID_W-1:0] task_id_res,
  input logic                     last
);
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after request");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    last |-> done) else $error("last without result");
  a_add_last: assert property (@(posedge clk) disable iff (rst)
    (done && (status == tws_pkg::ST_ADDED || status == tws_pkg::ST_REJECTED ||
      status == tws_pkg::ST_NONE)) |-> last) else $error("single result not last");
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != tws_pkg::ST_EXPIRED) |-> (task_id_res == '0))
    else $error("id set on non-expire result");
endmodule

bind timing_wheel_scheduler tws_checker u_tws_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .task_id_res(task_id_res), .last(last)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the timing wheel scheduler: a queue-fed driver
// issues add and expire requests with random gaps, a monitor predicts the
// expected results of every accepted request and compares each result in order
// ----------------------------------------------------------------------------
module tb;
  localparam int SLOTS = tws_pkg::WHEEL_SLOTS_DEF;
  localparam int TASKS = tws_pkg::MAX_TASKS_DEF;
  localparam int TW_B  = tws_pkg::TIME_W;
  localparam int ID_B  = tws_pkg::ID_W;
  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_EXPIRE = 1'b1;
  localparam logic [TW_B-1:0] TMAX = {TW_B{1'b1}};

  typedef struct packed {
    logic              action;
    logic [TW_B-1:0]   now;
    logic [ID_B-1:0]   id;
    logic [TW_B-1:0]   exp;
  } request_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_B-1:0] id;
    logic            last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic action = 1'b0;
  logic [TW_B-1:0] now = '0;
  logic [ID_B-1:0] task_id = '0;
  logic [TW_B-1:0] expire_time = '0;
  logic busy, done, last;
  logic [1:0] status;
  logic [ID_B-1:0] task_id_res;

  timing_wheel_scheduler dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .now(now), .task_id(task_id), .expire_time(expire_time), .done(done),
    .status(status), .task_id_res(task_id_res), .last(last)
  );

  request_t request_q[$];
  outcome_t outcome_q[$];
  int errors = 0;

  // wheel copy
  bit              w_started;
  bit [TW_B-1:0]   w_start_time;
  int              w_start_slot;
  bit [ID_B-1:0]   w_head[SLOTS];
  bit [ID_B-1:0]   w_tail[SLOTS];
  bit              w_busy_slot[SLOTS];
  bit [ID_B-1:0]   w_next[TASKS];
  bit              w_pending[TASKS];

  initial forever #6 clk = ~clk;

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report(input string what, input int exp_v, input int got_v);
    $display("mismatch %s: expected %0d got %0d", what, exp_v, got_v);
    errors++;
  endtask

  function automatic outcome_t mk(input logic [1:0] s, input logic [ID_B-1:0] i,
                                  input logic l);
    outcome_t o;
    o.status = s; o.id = i; o.last = l;
    return o;
  endfunction

  function automatic void predict_wheel(input request_t r);
    logic [63:0] diff, cnt;
    int slot, t, tl, guard, n;
    if (!w_started) begin
      w_started = 1; w_start_time = r.now; w_start_slot = 0;
    end
    if (r.action == ACT_ADD) begin
      diff = {16'b0, r.exp} - {16'b0, w_start_time};
      if (r.now < w_start_time || r.exp < r.now || w_pending[r.id] || diff >= SLOTS) begin
        outcome_q.push_back(mk(tws_pkg::ST_REJECTED, '0, 1'b1));
      end else begin
        slot = (w_start_slot + int'(diff)) % SLOTS;
        if (w_busy_slot[slot]) w_next[w_tail[slot]] = r.id;
        else begin
          w_head[slot] = r.id; w_busy_slot[slot] = 1;
        end
        w_tail[slot] = r.id;
        w_pending[r.id] = 1;
        outcome_q.push_back(mk(tws_pkg::ST_ADDED, '0, 1'b1));
      end
    end else if (r.now < w_start_time) begin
      outcome_q.push_back(mk(tws_pkg::ST_NONE, '0, 1'b1));
    end else begin
      n = 0;
      cnt = {16'b0, r.now} - {16'b0, w_start_time} + 64'd1;
      if (cnt > SLOTS) cnt = SLOTS;
      for (int i = 0; i < int'(cnt); i++) begin
        slot = (w_start_slot + i) % SLOTS;
        if (w_busy_slot[slot]) begin
          t = int'(w_head[slot]); tl = int'(w_tail[slot]); guard = 0;
          forever begin
            if (n < TASKS && w_pending[t]) begin
              outcome_q.push_back(mk(tws_pkg::ST_EXPIRED, t[ID_B-1:0], 1'b0));
              n++;
            end
            w_pending[t] = 0;
            guard++;
            if (t == tl || guard >= TASKS) break;
            t = int'(w_next[t]);
          end
          w_busy_slot[slot] = 0;
        end
      end
      w_start_time = r.now;
      w_start_slot = (w_start_slot + int'(cnt) - 1) % SLOTS;
      if (n == 0) outcome_q.push_back(mk(tws_pkg::ST_NONE, '0, 1'b1));
      else outcome_q[$].last = 1'b1;
    end
  endfunction

  function automatic request_t rq(input logic a, input logic [TW_B-1:0] t,
                                  input logic [ID_B-1:0] i, input logic [TW_B-1:0] e);
    request_t r;
    r.action = a; r.now = t; r.id = i; r.exp = e;
    return r;
  endfunction

  // driver
  int gap = 0;
  bit calm = 0;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start && $urandom_range(0, 29) == 0) calm = !calm;
      if (start && !calm)
        gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      if (gap > 0 || request_q.size() == 0) begin
        if (gap > 0) gap--;
        start <= 1'b0;
      end else begin
        request_t r;
        r = request_q.pop_front();
        start <= 1'b1;
        action <= r.action;
        now <= r.now;
        task_id <= r.id;
        expire_time <= r.exp;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (outcome_q.size() == 0) report("unexpected result", 0, status);
        else begin
          outcome_t o;
          o = outcome_q.pop_front();
          if (status !== o.status) report("status", o.status, status);
          if (task_id_res !== o.id) report("task_id_res", o.id, task_id_res);
          if (last !== o.last) report("last", o.last, last);
        end
      end
      if (start && !busy) predict_wheel(rq(action, now, task_id, expire_time));
    end
  end

  initial begin
    logic [TW_B-1:0] base, t;
    int roll;
    // directed
    request_q.push_back(rq(ACT_ADD, 48'd1000, 6'd0, 48'd1000));
    request_q.push_back(rq(ACT_ADD, 48'd1000, 6'd63, 48'd1063));
    request_q.push_back(rq(ACT_ADD, 48'd1000, 6'd1, 48'd1064));
    request_q.push_back(rq(ACT_ADD, 48'd1005, 6'd2, 48'd1004));
    request_q.push_back(rq(ACT_ADD, 48'd1000, 6'd0, 48'd1010));
    request_q.push_back(rq(ACT_ADD, 48'd999, 6'd3, 48'd1010));
    request_q.push_back(rq(ACT_EXPIRE, 48'd10, 6'd0, 48'd0));
    request_q.push_back(rq(ACT_ADD, 48'd1000, 6'd5, 48'd1003));
    request_q.push_back(rq(ACT_ADD, 48'd1001, 6'd6, 48'd1003));
    request_q.push_back(rq(ACT_ADD, 48'd1002, 6'd7, 48'd1003));
    request_q.push_back(rq(ACT_EXPIRE, 48'd1000, 6'd0, 48'd0));
    request_q.push_back(rq(ACT_EXPIRE, 48'd1001, 6'd0, 48'd0));
    request_q.push_back(rq(ACT_EXPIRE, 48'd1003, 6'd0, 48'd0));
    request_q.push_back(rq(ACT_ADD, 48'd1003, 6'd8, 48'd1066));
    request_q.push_back(rq(ACT_EXPIRE, 48'd1500, 6'd0, 48'd0));
    request_q.push_back(rq(ACT_EXPIRE, 48'd1500, 6'd0, 48'd0));
    base = 48'd2000;
    request_q.push_back(rq(ACT_EXPIRE, base, 6'd0, 48'd0));
    // random
    for (int k = 0; k < 400; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        request_q.push_back(rq(ACT_ADD, TW_B'({$urandom, $urandom}), ID_B'($urandom),
                               TW_B'({$urandom, $urandom})));
      end else if (roll < 74) begin
        t = base + $urandom_range(0, 8);
        roll = $urandom_range(0, 19);
        request_q.push_back(rq(ACT_ADD, t, ID_B'($urandom),
          roll == 0 ? t - 1 : roll == 1 ? base + $urandom_range(60, 80)
                            : t + $urandom_range(0, 50)));
      end else begin
        t = base + (($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(0, 20));
        request_q.push_back(rq(ACT_EXPIRE, t, ID_B'($urandom),
                               TW_B'({$urandom, $urandom})));
        base = t;
      end
    end
    // top of the time range
    request_q.push_back(rq(ACT_EXPIRE, TMAX, 6'd0, 48'd0));
    request_q.push_back(rq(ACT_ADD, TMAX, 6'd63, TMAX));
    request_q.push_back(rq(ACT_ADD, TMAX, 6'd0, TMAX));
    request_q.push_back(rq(ACT_EXPIRE, TMAX, 6'd0, 48'd0));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (request_q.size() == 0);
    @(posedge clk);
    while (start || busy || outcome_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && outcome_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
